FILE: sv/ilt_pkg.sv
// Shared types, codes and constants for the INI line tokenizer.
package ilt_pkg;

  // Lexer modes
  localparam logic [3:0] MODE_IDLE      = 4'd0;
  localparam logic [3:0] MODE_COMMENT   = 4'd1;
  localparam logic [3:0] MODE_SEC_START = 4'd2;
  localparam logic [3:0] MODE_SEC_BODY  = 4'd3;
  localparam logic [3:0] MODE_SEC_ESC   = 4'd4;
  localparam logic [3:0] MODE_KEY       = 4'd5;
  localparam logic [3:0] MODE_VALUE     = 4'd6;
  localparam logic [3:0] MODE_SKIP      = 4'd7;

  // Event codes
  localparam logic [3:0] EV_SEC_CHAR  = 4'd0;
  localparam logic [3:0] EV_KEY_CHAR  = 4'd1;
  localparam logic [3:0] EV_VAL_CHAR  = 4'd2;
  localparam logic [3:0] EV_SEC_DONE  = 4'd3;
  localparam logic [3:0] EV_SEC_EMPTY = 4'd4;
  localparam logic [3:0] EV_TAG       = 4'd5;
  localparam logic [3:0] EV_KEYVAL    = 4'd6;
  localparam logic [3:0] EV_SEC_ERR   = 4'd7;
  localparam logic [3:0] EV_INVALID   = 4'd8;
  localparam logic [3:0] EV_END       = 4'd9;

  // Input kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOWZ   = 8'h7A;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  // Result queue depth (at least 2)
  localparam int ILT_RES_DEPTH = 4;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  char_out;
    logic [15:0] line_number;
  } out_word_t;

  // Results of one lexer step: up to two words
  typedef struct packed {
    logic [1:0] count;
    out_word_t  r0;
    out_word_t  r1;
  } step_res_t;

endpackage

FILE: sv/ini_line_tokenizer.sv
// Top level of the INI line tokenizer: lexer state, step logic and result queue.
//
//   channel | direction | word type  | handshake
//   src     | in        | in_word_t  | src_valid / src_stall
//   res     | out       | out_word_t | res_valid / res_stall
//
// A byte is taken every cycle while the result queue has room for two words;
// its words are written to the queue as it is taken and leave it one per cycle
// while res_stall is low. Items that give two words (an escape not before ']',
// end of stream inside a section, key or value) may fill the queue.
// Reset sets the mode to idle, the line count to one and empties the queue.
// res_stall backs up the queue, which then raises src_stall.
module ini_line_tokenizer import ilt_pkg::*; #(
  parameter int ResDepth = ILT_RES_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_stall,
  input  in_word_t  src_word,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  logic [3:0]  mode, mode_next;
  logic [15:0] line, line_next;
  step_res_t   step;
  logic        room2;
  logic        accept;

  assign accept    = src_valid && !src_stall;
  assign src_stall = !room2;

  ilt_step u_step (
    .mode      (mode),
    .line      (line),
    .word      (src_word),
    .mode_next (mode_next),
    .line_next (line_next),
    .res       (step)
  );

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      line <= 16'd1;
    end else if (accept) begin
      mode <= mode_next;
      line <= line_next;
    end
  end

  ilt_fifo #(
    .Depth (ResDepth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (step),
    .wr_en     (accept),
    .room2     (room2),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

`ifndef SYNTHESIS
  // end of stream always yields at least the end word
  a_eos_result: assert property (@(posedge clk) disable iff (rst)
    accept && (src_word.kind == KIND_EOS || src_word.byte_value == CH_NUL) |=> res_valid)
    else $error("end of stream gave no result word");

  // end of stream returns the lexer to idle
  a_eos_idle: assert property (@(posedge clk) disable iff (rst)
    accept && (src_word.kind == KIND_EOS || src_word.byte_value == CH_NUL)
    |=> mode == MODE_IDLE)
    else $error("lexer not idle after end of stream");

  // line count never drops to zero
  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_word.line_number != 16'd0)
    else $error("line number zero on output");

  // queue is empty and open right after reset
  a_reset_open: assert property (@(posedge clk)
    rst |=> !src_stall && !res_valid)
    else $error("queue not empty after reset");
`endif

endmodule

FILE: sv/ilt_step.sv
// Combinational lexer step: next mode, next line count and up to two result words.
module ilt_step import ilt_pkg::*; (
  input  logic [3:0]  mode,
  input  logic [15:0] line,
  input  in_word_t    word,
  output logic [3:0]  mode_next,
  output logic [15:0] line_next,
  output step_res_t   res
);

  logic       eos;
  logic       bump;
  logic [7:0] b;
  logic [1:0] cnt;
  logic [3:0] ev0, ev1;
  logic [7:0] ch0, ch1;

  assign b   = word.byte_value;
  assign eos = (word.kind == KIND_EOS) || (b == CH_NUL);

  // mode transition and event selection
  always_comb begin
    mode_next = mode;
    bump      = 1'b0;
    cnt       = 2'd0;
    ev0       = EV_END;
    ch0       = CH_NUL;
    ev1       = EV_END;
    ch1       = CH_NUL;
    if (eos) begin
      mode_next = MODE_IDLE;
      unique case (mode)
        MODE_SEC_START, MODE_SEC_BODY, MODE_SEC_ESC: begin
          cnt = 2'd2;
          ev0 = EV_SEC_ERR;
        end
        MODE_KEY, MODE_VALUE: begin
          bump = 1'b1;
          cnt  = 2'd2;
          ev0  = EV_KEYVAL;
        end
        MODE_COMMENT, MODE_SKIP: begin
          bump = 1'b1;
          cnt  = 2'd1;
        end
        default: begin
          cnt = 2'd1;
        end
      endcase
    end else begin
      unique case (mode)
        MODE_COMMENT, MODE_SKIP: begin
          if (b == CH_LF) begin
            bump      = 1'b1;
            mode_next = MODE_IDLE;
          end
        end
        MODE_SEC_START, MODE_SEC_BODY: begin
          priority if (b == CH_RBRACK) begin
            cnt       = 2'd1;
            ev0       = (mode == MODE_SEC_START) ? EV_SEC_EMPTY : EV_SEC_DONE;
            mode_next = MODE_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_next = MODE_SEC_ESC;
          end else if (b == CH_LF) begin
            cnt       = 2'd1;
            ev0       = EV_SEC_ERR;
            mode_next = MODE_IDLE;
          end else begin
            cnt       = 2'd1;
            ev0       = EV_SEC_CHAR;
            ch0       = b;
            mode_next = MODE_SEC_BODY;
          end
        end
        MODE_SEC_ESC: begin
          cnt = 2'd2;
          ev0 = EV_SEC_CHAR;
          ch0 = CH_BSLASH;
          priority if (b == CH_RBRACK) begin
            cnt       = 2'd1;
            ch0       = CH_RBRACK;
            mode_next = MODE_SEC_BODY;
          end else if (b == CH_LF) begin
            ev1       = EV_SEC_ERR;
            mode_next = MODE_IDLE;
          end else begin
            ev1       = EV_SEC_CHAR;
            ch1       = b;
            mode_next = MODE_SEC_BODY;
          end
        end
        MODE_KEY: begin
          priority if (b == CH_EQUAL) begin
            mode_next = MODE_VALUE;
          end else if (b == CH_LF) begin
            bump      = 1'b1;
            cnt       = 2'd1;
            ev0       = EV_TAG;
            mode_next = MODE_IDLE;
          end else begin
            cnt = 2'd1;
            ev0 = EV_KEY_CHAR;
            ch0 = b;
          end
        end
        MODE_VALUE: begin
          if (b == CH_LF || b == CH_CR) begin
            bump      = 1'b1;
            cnt       = 2'd1;
            ev0       = EV_KEYVAL;
            mode_next = MODE_IDLE;
          end else begin
            cnt = 2'd1;
            ev0 = EV_VAL_CHAR;
            ch0 = b;
          end
        end
        default: begin
          // between tokens
          mode_next = MODE_IDLE;
          priority if (b == CH_SPACE || b == CH_TAB) begin
            mode_next = MODE_IDLE;
          end else if (b == CH_LF) begin
            bump = 1'b1;
          end else if (b == CH_SEMI) begin
            mode_next = MODE_COMMENT;
          end else if (b == CH_LBRACK) begin
            mode_next = MODE_SEC_START;
          end else if (b == CH_EQUAL) begin
            mode_next = MODE_VALUE;
          end else if (b > CH_SPACE && b <= CH_LOWZ) begin
            cnt       = 2'd1;
            ev0       = EV_KEY_CHAR;
            ch0       = b;
            mode_next = MODE_KEY;
          end else begin
            cnt       = 2'd1;
            ev0       = EV_INVALID;
            ch0       = b;
            mode_next = MODE_SKIP;
          end
        end
      endcase
    end
  end

  // saturating line count; every word of an item carries the updated count
  assign line_next = (bump && line != LINE_MAX) ? line + 16'd1 : line;

  assign res.count          = cnt;
  assign res.r0.event_res   = ev0;
  assign res.r0.char_out    = ch0;
  assign res.r0.line_number = line_next;
  assign res.r1.event_res   = ev1;
  assign res.r1.char_out    = ch1;
  assign res.r1.line_number = line_next;

endmodule

FILE: sv/ilt_fifo.sv
// Result queue: takes up to two words per cycle, hands out one while res_stall is low.
module ilt_fifo import ilt_pkg::*; #(
  parameter int Depth = ILT_RES_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  step_res_t wr,
  input  logic      wr_en,
  output logic      room2,
  output logic      res_valid,
  input  logic      res_stall,
  output out_word_t res_word
);

  localparam int PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LAST = PW'(Depth - 1);

  out_word_t        mem [Depth];
  logic [PW-1:0]    rd_ptr, rd_ptr_next;
  logic [PW-1:0]    wr_ptr, wr_ptr_next, wr_ptr1;
  logic [CW-1:0]    level, level_next;
  logic [1:0]       wr_cnt;
  logic             rd;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == LAST) ? '0 : p + PW'(1);
  endfunction

  assign wr_cnt    = wr_en ? wr.count : 2'd0;
  assign rd        = res_valid && !res_stall;
  assign res_valid = (level != '0);
  assign res_word  = mem[rd_ptr];
  assign room2     = (level <= CW'(Depth - 2));
  assign wr_ptr1   = inc(wr_ptr);

  // pointer and fill level update
  always_comb begin
    rd_ptr_next = rd ? inc(rd_ptr) : rd_ptr;
    unique case (wr_cnt)
      2'd1:    wr_ptr_next = wr_ptr1;
      2'd2:    wr_ptr_next = inc(wr_ptr1);
      default: wr_ptr_next = wr_ptr;
    endcase
    level_next = level + CW'(wr_cnt) - CW'(rd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      level  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
      level  <= level_next;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_cnt != 2'd0) begin
      mem[wr_ptr] <= wr.r0;
    end
    if (wr_cnt == 2'd2) begin
      mem[wr_ptr1] <= wr.r1;
    end
  end

endmodule
